FILE: rtl/cos_pkg.sv
// ----------------------------------------------------------------------------
// cos_pkg: converter overload supervisor shared definitions
// Command codes, configuration indexes and reset values, and the request,
// configuration and result structures passed between the supervisor modules.
// ----------------------------------------------------------------------------
package cos_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 16;

  localparam int CMD_WIDTH   = 3;
  localparam int ADC_WIDTH   = 2;
  localparam int TICKS_WIDTH = 16;
  localparam int CFG_IDX_WIDTH = 3;

  localparam logic [CMD_WIDTH-1:0] CMD_NONE  = 3'd0;
  localparam logic [CMD_WIDTH-1:0] CMD_ON    = 3'd1;
  localparam logic [CMD_WIDTH-1:0] CMD_OFF   = 3'd2;
  localparam logic [CMD_WIDTH-1:0] CMD_CLEAR = 3'd3;
  localparam logic [CMD_WIDTH-1:0] CMD_USER  = 3'd4;
  localparam logic [CMD_WIDTH-1:0] CMD_BLINK = 3'd5;

  // adc_cmd bits: force off wins over release
  localparam int ADC_FORCE_BIT   = 0;
  localparam int ADC_RELEASE_BIT = 1;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_PROT   = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_TRIP   = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_SETTLE = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_MINOFF = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_USER   = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_BLINK  = 3'd5;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_WARN   = 3'd6;

  localparam logic [TICKS_WIDTH-1:0] TRIP_RESET   = 16'd10;
  localparam logic [TICKS_WIDTH-1:0] SETTLE_RESET = 16'd50;
  localparam logic [TICKS_WIDTH-1:0] MINOFF_RESET = 16'd100;
  localparam logic [TICKS_WIDTH-1:0] USER_RESET   = 16'd100;
  localparam logic [TICKS_WIDTH-1:0] BLINK_RESET  = 16'd50;
  localparam logic [TICKS_WIDTH-1:0] WARN_RESET   = 16'd500;

  typedef struct packed {
    logic                   guard_en;
    logic [TICKS_WIDTH-1:0] trip_ticks;
    logic [TICKS_WIDTH-1:0] settle_ticks;
    logic [TICKS_WIDTH-1:0] min_off_ticks;
    logic [TICKS_WIDTH-1:0] user_ticks;
    logic [TICKS_WIDTH-1:0] blink_ticks;
    logic [TICKS_WIDTH-1:0] warn_ticks;
  } cfg_t;

  typedef struct packed {
    logic [CMD_WIDTH-1:0] cmd;
    logic [ADC_WIDTH-1:0] adc_cmd;
    logic                 overload_pin;
    logic                 top_overload_flag;
  } item_t;

  typedef struct packed {
    logic converter_enable;
    logic is_on;
    logic is_off;
    logic is_overloaded;
    logic held_off_by_adc;
    logic off_timer_running;
    logic user_timer_expired;
    logic run_led;
    logic led_red;
    logic trip_event;
    logic sound_warning;
  } res_t;

endpackage

FILE: rtl/converter_overload_supervisor.sv
// ----------------------------------------------------------------------------
// converter_overload_supervisor: converter on/off and overload protection
// Request register, single-pass supervisor update and result register.
// ----------------------------------------------------------------------------
// One request is one supervision tick and yields exactly one result. A new
// request is taken every cycle while the result register is free or being
// drained; a request waits in the request register until it advances, and
// then the single-pass logic commits the whole state update and loads the
// result register, which offers the result. A stalled result is held in the
// result register while the next request waits in the request register.
// Configuration writes are always accepted and take effect on the next tick;
// write them only while no request is in flight.
module converter_overload_supervisor #(
  parameter int COUNT_WIDTH = cos_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [cos_pkg::CMD_WIDTH-1:0]     cmd,
  input  logic [cos_pkg::ADC_WIDTH-1:0]     adc_cmd,
  input  logic                              overload_pin,
  input  logic                              top_overload_flag,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              converter_enable,
  output logic                              is_on,
  output logic                              is_off,
  output logic                              is_overloaded,
  output logic                              held_off_by_adc,
  output logic                              off_timer_running,
  output logic                              user_timer_expired,
  output logic                              run_led,
  output logic                              led_red,
  output logic                              trip_event,
  output logic                              sound_warning,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cos_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [cos_pkg::TICKS_WIDTH-1:0]   cfg_data
);

  cos_pkg::cfg_t  cfg;
  cos_pkg::item_t req;
  cos_pkg::res_t  core_res;
  cos_pkg::res_t  res;
  logic           req_valid;
  logic           adv;

  assign cfg_ready = 1'b1;
  assign adv       = req_valid && (!out_valid || out_ready);
  assign in_ready  = !req_valid || adv;

  cos_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req.cmd               <= cmd;
      req.adc_cmd           <= adc_cmd;
      req.overload_pin      <= overload_pin;
      req.top_overload_flag <= top_overload_flag;
    end
  end

  cos_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .item   (req),
    .cfg    (cfg),
    .result (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= core_res;
    end
  end

  assign converter_enable   = res.converter_enable;
  assign is_on              = res.is_on;
  assign is_off             = res.is_off;
  assign is_overloaded      = res.is_overloaded;
  assign held_off_by_adc    = res.held_off_by_adc;
  assign off_timer_running  = res.off_timer_running;
  assign user_timer_expired = res.user_timer_expired;
  assign run_led            = res.run_led;
  assign led_red            = res.led_red;
  assign trip_event         = res.trip_event;
  assign sound_warning      = res.sound_warning;

endmodule

FILE: rtl/cos_cfg.sv
// ----------------------------------------------------------------------------
// cos_cfg: configuration registers
// Holds the seven supervisor settings; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module cos_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [cos_pkg::CFG_IDX_WIDTH-1:0]  wr_index,
  input  logic [cos_pkg::TICKS_WIDTH-1:0]    wr_data,
  output cos_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.guard_en          <= 1'b1;
      cfg.trip_ticks        <= cos_pkg::TRIP_RESET;
      cfg.settle_ticks      <= cos_pkg::SETTLE_RESET;
      cfg.min_off_ticks     <= cos_pkg::MINOFF_RESET;
      cfg.user_ticks        <= cos_pkg::USER_RESET;
      cfg.blink_ticks       <= cos_pkg::BLINK_RESET;
      cfg.warn_ticks        <= cos_pkg::WARN_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        cos_pkg::CFG_PROT:   cfg.guard_en          <= wr_data[0];
        cos_pkg::CFG_TRIP:   cfg.trip_ticks        <= wr_data;
        cos_pkg::CFG_SETTLE: cfg.settle_ticks      <= wr_data;
        cos_pkg::CFG_MINOFF: cfg.min_off_ticks     <= wr_data;
        cos_pkg::CFG_USER:   cfg.user_ticks        <= wr_data;
        cos_pkg::CFG_BLINK:  cfg.blink_ticks       <= wr_data;
        cos_pkg::CFG_WARN:   cfg.warn_ticks        <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/cos_core.sv
// ----------------------------------------------------------------------------
// cos_core: supervisor state and single-tick update
// Keeps the status bits and six countdown counters, computes one result per
// request and commits the new state when the request advances.
// ----------------------------------------------------------------------------
module cos_core #(
  parameter int COUNT_WIDTH = cos_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  cos_pkg::item_t item,
  input  cos_pkg::cfg_t  cfg,
  output cos_pkg::res_t  result
);

  localparam logic [COUNT_WIDTH-1:0] ZERO = '0;
  localparam logic [COUNT_WIDTH-1:0] ONE  = COUNT_WIDTH'(1);

  function automatic logic [COUNT_WIDTH-1:0] load(input logic [cos_pkg::TICKS_WIDTH-1:0] v);
    logic [COUNT_WIDTH+cos_pkg::TICKS_WIDTH-1:0] w;
    w = {{COUNT_WIDTH{1'b0}}, v};
    return w[COUNT_WIDTH-1:0];
  endfunction

  logic on_bit, off_bit, overloaded_bit, adc_off_bit, off_timer_flag, user_expired_flag;
  logic [COUNT_WIDTH-1:0] settle_count, trip_count, off_count, user_count, blink_count;
  logic [COUNT_WIDTH-1:0] warn_count;

  logic on_bit_next, off_bit_next, overloaded_bit_next, adc_off_bit_next;
  logic off_timer_flag_next, user_expired_flag_next;
  logic [COUNT_WIDTH-1:0] settle_count_next, trip_count_next, off_count_next;
  logic [COUNT_WIDTH-1:0] user_count_next, blink_count_next, warn_count_next;

  logic check, raw, trip, sound;

  always_comb begin
    check = 1'b0;
    settle_count_next = settle_count;
    if (off_bit || adc_off_bit || !cfg.guard_en) begin
      settle_count_next = load(cfg.settle_ticks);
    end else if (settle_count != ZERO) begin
      settle_count_next = settle_count - ONE;
    end else begin
      check = 1'b1;
    end
    raw = check && item.overload_pin;

    trip_count_next = trip_count;
    if (!raw) begin
      trip_count_next = load(cfg.trip_ticks);
    end else if (trip_count != ZERO) begin
      trip_count_next = trip_count - ONE;
    end
    trip = (trip_count_next == ZERO);

    on_bit_next         = on_bit;
    off_bit_next        = off_bit;
    overloaded_bit_next = overloaded_bit;
    off_count_next      = off_count;
    if (trip) begin
      on_bit_next         = 1'b0;
      off_bit_next        = 1'b1;
      overloaded_bit_next = 1'b1;
      off_count_next      = load(cfg.min_off_ticks);
    end

    if (item.cmd == cos_pkg::CMD_CLEAR) begin
      overloaded_bit_next = 1'b0;
    end
    if (item.cmd == cos_pkg::CMD_OFF && !off_bit_next) begin
      on_bit_next    = 1'b0;
      off_bit_next   = 1'b1;
      off_count_next = load(cfg.min_off_ticks);
    end else if (item.cmd == cos_pkg::CMD_ON && !on_bit_next) begin
      off_bit_next = 1'b0;
      on_bit_next  = 1'b1;
    end
    user_count_next = user_count;
    if (item.cmd == cos_pkg::CMD_USER) begin
      user_count_next = load(cfg.user_ticks);
    end
    blink_count_next = blink_count;
    if (item.cmd == cos_pkg::CMD_BLINK) begin
      blink_count_next = load(cfg.blink_ticks);
    end

    adc_off_bit_next = adc_off_bit;
    if (item.adc_cmd[cos_pkg::ADC_FORCE_BIT]) begin
      adc_off_bit_next = 1'b1;
    end else if (item.adc_cmd[cos_pkg::ADC_RELEASE_BIT]) begin
      adc_off_bit_next = 1'b0;
    end

    result.converter_enable = on_bit_next && !off_bit_next && !adc_off_bit_next;
    result.run_led          = on_bit_next && (blink_count_next == ZERO);

    sound = 1'b0;
    warn_count_next = warn_count;
    if (raw && warn_count == ZERO) begin
      sound = 1'b1;
      warn_count_next = load(cfg.warn_ticks);
    end

    if (off_count_next != ZERO) begin
      off_count_next = off_count_next - ONE;
      off_timer_flag_next = 1'b1;
    end else begin
      off_timer_flag_next = 1'b0;
    end
    if (user_count_next != ZERO) begin
      user_count_next = user_count_next - ONE;
      user_expired_flag_next = 1'b0;
    end else begin
      user_expired_flag_next = 1'b1;
    end
    if (blink_count_next != ZERO) begin
      blink_count_next = blink_count_next - ONE;
    end
    if (warn_count_next != ZERO) begin
      warn_count_next = warn_count_next - ONE;
    end

    result.is_on              = on_bit_next;
    result.is_off             = off_bit_next;
    result.is_overloaded      = overloaded_bit_next;
    result.held_off_by_adc    = adc_off_bit_next;
    result.off_timer_running  = off_timer_flag_next;
    result.user_timer_expired = user_expired_flag_next;
    result.led_red            = raw || item.top_overload_flag;
    result.trip_event         = trip;
    result.sound_warning      = sound;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      on_bit            <= 1'b0;
      off_bit           <= 1'b1;
      overloaded_bit    <= 1'b0;
      adc_off_bit       <= 1'b0;
      off_timer_flag    <= 1'b0;
      user_expired_flag <= 1'b0;
      settle_count      <= ZERO;
      trip_count        <= ZERO;
      off_count         <= ZERO;
      user_count        <= ZERO;
      blink_count       <= ZERO;
      warn_count        <= ZERO;
    end else if (adv) begin
      on_bit            <= on_bit_next;
      off_bit           <= off_bit_next;
      overloaded_bit    <= overloaded_bit_next;
      adc_off_bit       <= adc_off_bit_next;
      off_timer_flag    <= off_timer_flag_next;
      user_expired_flag <= user_expired_flag_next;
      settle_count      <= settle_count_next;
      trip_count        <= trip_count_next;
      off_count         <= off_count_next;
      user_count        <= user_count_next;
      blink_count       <= blink_count_next;
      warn_count        <= warn_count_next;
    end
  end

  a_on_off_exclusive: assert property (@(posedge clk) disable iff (rst)
    on_bit != off_bit)
    else $error("on and off status bits out of step");

  a_trip_forces_off: assert property (@(posedge clk) disable iff (rst)
    adv && trip && item.cmd != cos_pkg::CMD_ON |=> off_bit && !on_bit)
    else $error("trip did not switch the converter off");

  a_trip_latches_overload: assert property (@(posedge clk) disable iff (rst)
    adv && trip && item.cmd != cos_pkg::CMD_CLEAR |=> overloaded_bit)
    else $error("trip did not latch the overload status");

  a_sound_needs_check: assert property (@(posedge clk) disable iff (rst)
    sound |-> !off_bit && !adc_off_bit && cfg.guard_en && settle_count == ZERO)
    else $error("warning raised while the overload pin is masked");

  a_adc_hold: assert property (@(posedge clk) disable iff (rst)
    adv && item.adc_cmd == '0 |=> adc_off_bit == $past(adc_off_bit))
    else $error("ADC hold bit changed without an ADC command");

endmodule

FILE: sim/converter_overload_supervisor_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// converter_overload_supervisor_tb: self-checking bench for the supervisor
// Runs a short table of directed ticks, then random phases under several
// register settings and handshake idle patterns. Every request goes through a
// local tick predictor, and each result is compared field by field in order.
// ----------------------------------------------------------------------------
module converter_overload_supervisor_tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASES       = 11;
  localparam int PHASE_ITEMS  = 100;
  localparam int PRESSURE_PHASE = 5;
  localparam int HOLD_CYCLES  = 60;

  localparam logic [cos_pkg::CMD_WIDTH-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [cos_pkg::CMD_WIDTH-1:0] CMD_SPARE_7 = 3'd7;
  localparam logic [cos_pkg::ADC_WIDTH-1:0] ADC_NONE    = 2'b00;
  localparam logic [cos_pkg::ADC_WIDTH-1:0] ADC_FORCE   = 2'b01;
  localparam logic [cos_pkg::ADC_WIDTH-1:0] ADC_RELEASE = 2'b10;
  localparam logic [cos_pkg::ADC_WIDTH-1:0] ADC_BOTH    = 2'b11;
  localparam logic [cos_pkg::CFG_IDX_WIDTH-1:0] CFG_SPARE = 3'd7;

  // status while off: is_off and user_timer_expired set; led_red and held_off_by_adc added as named
  localparam cos_pkg::res_t RES_AT_RESET = 11'b00100010000;
  localparam cos_pkg::res_t RES_TOP_FLAG = 11'b00100010100;
  localparam cos_pkg::res_t RES_ADC_HELD = 11'b00101010100;

  typedef struct packed {
    cos_pkg::item_t it;
    logic           typed;
    cos_pkg::res_t  want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [cos_pkg::CMD_WIDTH-1:0] cmd = cos_pkg::CMD_NONE;
  logic [cos_pkg::ADC_WIDTH-1:0] adc_cmd = ADC_NONE;
  logic overload_pin = 1'b0;
  logic top_overload_flag = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic converter_enable, is_on, is_off, is_overloaded, held_off_by_adc;
  logic off_timer_running, user_timer_expired, run_led, led_red;
  logic trip_event, sound_warning;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [cos_pkg::CFG_IDX_WIDTH-1:0] cfg_index = cos_pkg::CFG_PROT;
  logic [cos_pkg::TICKS_WIDTH-1:0] cfg_data = '0;

  converter_overload_supervisor dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .adc_cmd(adc_cmd), .overload_pin(overload_pin),
    .top_overload_flag(top_overload_flag),
    .out_valid(out_valid), .out_ready(out_ready),
    .converter_enable(converter_enable), .is_on(is_on), .is_off(is_off),
    .is_overloaded(is_overloaded), .held_off_by_adc(held_off_by_adc),
    .off_timer_running(off_timer_running), .user_timer_expired(user_timer_expired),
    .run_led(run_led), .led_red(led_red), .trip_event(trip_event),
    .sound_warning(sound_warning),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of the registers
  logic                            reg_prot   = 1'b1;
  logic [cos_pkg::TICKS_WIDTH-1:0] reg_trip   = cos_pkg::TRIP_RESET;
  logic [cos_pkg::TICKS_WIDTH-1:0] reg_settle = cos_pkg::SETTLE_RESET;
  logic [cos_pkg::TICKS_WIDTH-1:0] reg_minoff = cos_pkg::MINOFF_RESET;
  logic [cos_pkg::TICKS_WIDTH-1:0] reg_user   = cos_pkg::USER_RESET;
  logic [cos_pkg::TICKS_WIDTH-1:0] reg_blink  = cos_pkg::BLINK_RESET;
  logic [cos_pkg::TICKS_WIDTH-1:0] reg_warn   = cos_pkg::WARN_RESET;

  // predictor copy of the supervisor state
  logic st_on = 1'b0, st_off = 1'b1, st_ovl = 1'b0, st_adc_off = 1'b0;
  logic st_off_timer = 1'b0, st_user_exp = 1'b0;
  logic [cos_pkg::COUNT_WIDTH_DEFAULT-1:0] settle_cnt = '0, trip_cnt = '0, off_cnt = '0;
  logic [cos_pkg::COUNT_WIDTH_DEFAULT-1:0] user_cnt = '0, blink_cnt = '0, warn_cnt = '0;

  cos_pkg::res_t expected_status_q[$];
  int   mismatches = 0;
  int   cycle_count = 0;
  int   stall_pct = 0;
  int   pressure_req = 0;
  int   pressure_served = 0;
  int   hold_left = 0;

  string field_names[11] = '{"converter_enable", "is_on", "is_off", "is_overloaded",
                             "held_off_by_adc", "off_timer_running", "user_timer_expired",
                             "run_led", "led_red", "trip_event", "sound_warning"};

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  task automatic supervise_tick(input cos_pkg::item_t it, output cos_pkg::res_t r);
    logic check, raw, trip, sound;
    check = 1'b0;
    trip = 1'b0;
    sound = 1'b0;
    if (st_off || st_adc_off || !reg_prot) settle_cnt = reg_settle;
    else if (settle_cnt != 0) settle_cnt--;
    else check = 1'b1;
    raw = check && it.overload_pin;
    if (!raw) trip_cnt = reg_trip;
    else if (trip_cnt != 0) trip_cnt--;
    if (trip_cnt == 0) begin
      st_on = 1'b0;
      st_off = 1'b1;
      st_ovl = 1'b1;
      off_cnt = reg_minoff;
      trip = 1'b1;
    end
    if (it.cmd == cos_pkg::CMD_CLEAR) st_ovl = 1'b0;
    if (it.cmd == cos_pkg::CMD_OFF && !st_off) begin
      st_on = 1'b0;
      st_off = 1'b1;
      off_cnt = reg_minoff;
    end else if (it.cmd == cos_pkg::CMD_ON && !st_on) begin
      st_off = 1'b0;
      st_on = 1'b1;
    end
    if (it.cmd == cos_pkg::CMD_USER) user_cnt = reg_user;
    if (it.cmd == cos_pkg::CMD_BLINK) blink_cnt = reg_blink;
    if (it.adc_cmd[cos_pkg::ADC_FORCE_BIT]) st_adc_off = 1'b1;
    else if (it.adc_cmd[cos_pkg::ADC_RELEASE_BIT]) st_adc_off = 1'b0;
    r.converter_enable = st_on && !st_off && !st_adc_off;
    r.run_led = st_on && blink_cnt == 0;
    if (raw && warn_cnt == 0) begin
      sound = 1'b1;
      warn_cnt = reg_warn;
    end
    if (off_cnt != 0) begin
      off_cnt--;
      st_off_timer = 1'b1;
    end else begin
      st_off_timer = 1'b0;
    end
    if (user_cnt != 0) begin
      user_cnt--;
      st_user_exp = 1'b0;
    end else begin
      st_user_exp = 1'b1;
    end
    if (blink_cnt != 0) blink_cnt--;
    if (warn_cnt != 0) warn_cnt--;
    r.is_on = st_on;
    r.is_off = st_off;
    r.is_overloaded = st_ovl;
    r.held_off_by_adc = st_adc_off;
    r.off_timer_running = st_off_timer;
    r.user_timer_expired = st_user_exp;
    r.led_red = raw || it.top_overload_flag;
    r.trip_event = trip;
    r.sound_warning = sound;
  endtask

  task automatic write_reg(input logic [cos_pkg::CFG_IDX_WIDTH-1:0] idx,
                           input logic [cos_pkg::TICKS_WIDTH-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      cos_pkg::CFG_PROT:   reg_prot = data[0];
      cos_pkg::CFG_TRIP:   reg_trip = data;
      cos_pkg::CFG_SETTLE: reg_settle = data;
      cos_pkg::CFG_MINOFF: reg_minoff = data;
      cos_pkg::CFG_USER:   reg_user = data;
      cos_pkg::CFG_BLINK:  reg_blink = data;
      cos_pkg::CFG_WARN:   reg_warn = data;
      default: ;
    endcase
  endtask

  task automatic send_request(input cos_pkg::item_t it, input int idle_pct,
                              input logic typed, input cos_pkg::res_t want);
    cos_pkg::res_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= it.cmd;
    adc_cmd <= it.adc_cmd;
    overload_pin <= it.overload_pin;
    top_overload_flag <= it.top_overload_flag;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    supervise_tick(it, r);
    expected_status_q.push_back(typed ? want : r);
  endtask

  task automatic wait_drained();
    while (expected_status_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic stim_row_t stim_row(input logic [cos_pkg::CMD_WIDTH-1:0] c,
                                         input logic [cos_pkg::ADC_WIDTH-1:0] a,
                                         input logic pin, input logic top,
                                         input logic typed, input cos_pkg::res_t want);
    stim_row_t s;
    s.it.cmd = c;
    s.it.adc_cmd = a;
    s.it.overload_pin = pin;
    s.it.top_overload_flag = top;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  function automatic logic [cos_pkg::TICKS_WIDTH-1:0] pick_ticks(input int hi);
    if ($urandom_range(7) == 0) return cos_pkg::TICKS_WIDTH'($urandom_range(65535));
    return cos_pkg::TICKS_WIDTH'($urandom_range(hi));
  endfunction

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (pressure_req != pressure_served) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      pressure_served <= pressure_served + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    cos_pkg::res_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = {converter_enable, is_on, is_off, is_overloaded, held_off_by_adc,
             off_timer_running, user_timer_expired, run_led, led_red,
             trip_event, sound_warning};
      if (expected_status_q.size() == 0) begin
        flag_mismatch("result with no request outstanding");
      end else begin
        want = expected_status_q.pop_front();
        for (int i = 0; i < 11; i++) begin
          if (got[10-i] !== want[10-i])
            flag_mismatch($sformatf("%s expected %b got %b", field_names[i],
                                    want[10-i], got[10-i]));
        end
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    cos_pkg::item_t it;
    logic pin_level;
    logic [cos_pkg::TICKS_WIDTH-1:0] v_trip, v_settle, v_minoff, v_user, v_blink, v_warn;
    logic v_prot;
    int idle_pct;
    int mode;
    int pick;
    pin_level = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(cos_pkg::CFG_PROT, 16'd1);
    write_reg(cos_pkg::CFG_TRIP, 16'd3);
    write_reg(cos_pkg::CFG_SETTLE, 16'd1);
    write_reg(cos_pkg::CFG_MINOFF, 16'd4);
    write_reg(cos_pkg::CFG_USER, 16'd3);
    write_reg(cos_pkg::CFG_BLINK, 16'd2);
    write_reg(cos_pkg::CFG_WARN, 16'd5);
    cfg_valid <= 1'b0;

    rows.push_back(stim_row(cos_pkg::CMD_NONE, ADC_NONE, 1'b0, 1'b0, 1'b1, RES_AT_RESET));
    rows.push_back(stim_row(cos_pkg::CMD_NONE, ADC_NONE, 1'b0, 1'b1, 1'b1, RES_TOP_FLAG));
    rows.push_back(stim_row(CMD_SPARE_7, ADC_BOTH, 1'b1, 1'b1, 1'b1, RES_ADC_HELD));
    rows.push_back(stim_row(CMD_SPARE_6, ADC_RELEASE, 1'b0, 1'b0, 1'b1, RES_AT_RESET));
    rows.push_back(stim_row(cos_pkg::CMD_ON, ADC_NONE, 1'b0, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(cos_pkg::CMD_ON, ADC_NONE, 1'b1, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(cos_pkg::CMD_NONE, ADC_NONE, 1'b1, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(cos_pkg::CMD_NONE, ADC_NONE, 1'b1, 1'b1, 1'b0, '0));
    rows.push_back(stim_row(cos_pkg::CMD_ON, ADC_NONE, 1'b1, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(cos_pkg::CMD_NONE, ADC_NONE, 1'b1, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(cos_pkg::CMD_CLEAR, ADC_NONE, 1'b0, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(cos_pkg::CMD_ON, ADC_FORCE, 1'b0, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(cos_pkg::CMD_NONE, ADC_NONE, 1'b1, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(cos_pkg::CMD_USER, ADC_RELEASE, 1'b0, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(cos_pkg::CMD_BLINK, ADC_NONE, 1'b0, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(cos_pkg::CMD_NONE, ADC_NONE, 1'b0, 1'b1, 1'b0, '0));
    rows.push_back(stim_row(cos_pkg::CMD_OFF, ADC_NONE, 1'b0, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(cos_pkg::CMD_OFF, ADC_NONE, 1'b1, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(cos_pkg::CMD_NONE, ADC_NONE, 1'b0, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(cos_pkg::CMD_NONE, ADC_BOTH, 1'b0, 1'b0, 1'b0, '0));
    rows.push_back(stim_row(CMD_SPARE_7, ADC_RELEASE, 1'b1, 1'b1, 1'b0, '0));
    rows.push_back(stim_row(cos_pkg::CMD_CLEAR, ADC_NONE, 1'b0, 1'b0, 1'b0, '0));
    foreach (rows[i]) send_request(rows[i].it, 0, rows[i].typed, rows[i].want);
    in_valid <= 1'b0;
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      v_prot = ($urandom_range(9) != 0);
      v_trip = pick_ticks(6);
      if (v_trip == 0) v_trip = 16'd1;
      v_settle = pick_ticks(5);
      v_minoff = pick_ticks(8);
      v_user = pick_ticks(8);
      v_blink = pick_ticks(6);
      v_warn = pick_ticks(10);
      case (p)
        1: begin
          v_prot = 1'b1;
          {v_trip, v_settle, v_minoff, v_user, v_blink, v_warn} = '1;
        end
        2: begin
          v_prot = 1'b1;
          {v_trip, v_settle, v_minoff, v_user, v_blink, v_warn} = '0;
        end
        3: v_prot = 1'b0;
        4: begin
          v_trip = 16'd1;
          v_settle = 16'd0;
          v_warn = 16'd0;
        end
        default: ;
      endcase
      write_reg(cos_pkg::CFG_PROT,
                {(cos_pkg::TICKS_WIDTH-1)'($urandom_range(32767)), v_prot});
      write_reg(cos_pkg::CFG_TRIP, v_trip);
      write_reg(cos_pkg::CFG_SETTLE, v_settle);
      write_reg(cos_pkg::CFG_MINOFF, v_minoff);
      write_reg(cos_pkg::CFG_USER, v_user);
      write_reg(cos_pkg::CFG_BLINK, v_blink);
      write_reg(cos_pkg::CFG_WARN, v_warn);
      if (p == 6) write_reg(CFG_SPARE, cos_pkg::TICKS_WIDTH'($urandom_range(65535)));
      cfg_valid <= 1'b0;

      mode = p % 4;
      idle_pct = (mode == 1) ? 45 : (mode == 3) ? 24 : 0;
      stall_pct <= (mode == 2) ? 45 : (mode == 3) ? 24 : 0;
      if (p == PRESSURE_PHASE) begin
        idle_pct = 0;
        pressure_req <= pressure_req + 1;
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(9) == 0) begin
          it = cos_pkg::item_t'(7'($urandom_range(127)));
        end else begin
          if ($urandom_range(99) < 15) pin_level = ~pin_level;
          pick = $urandom_range(99);
          it.cmd = (pick < 68) ? cos_pkg::CMD_NONE : (pick < 80) ? cos_pkg::CMD_ON :
                   (pick < 85) ? cos_pkg::CMD_OFF : (pick < 90) ? cos_pkg::CMD_CLEAR :
                   (pick < 94) ? cos_pkg::CMD_USER : (pick < 98) ? cos_pkg::CMD_BLINK :
                   (pick < 99) ? CMD_SPARE_6 : CMD_SPARE_7;
          pick = $urandom_range(99);
          it.adc_cmd = (pick < 85) ? ADC_NONE : (pick < 90) ? ADC_FORCE :
                       (pick < 98) ? ADC_RELEASE : ADC_BOTH;
          it.overload_pin = pin_level;
          it.top_overload_flag = ($urandom_range(4) == 0);
        end
        send_request(it, idle_pct, 1'b0, '0);
      end
      in_valid <= 1'b0;
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_status_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
